[src/psg_tone_noise_envelope_core_assert.svh]
// ============================================================================
// psg_tone_noise_envelope_core_assert.svh
// Assertion macros used by the checker file.
// ============================================================================
`ifndef PSG_TONE_NOISE_ENVELOPE_CORE_ASSERT_SVH
`define PSG_TONE_NOISE_ENVELOPE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define PSG_ASSERT_IMPLY(label, lhs, rhs) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |-> (rhs)) \
        else $error("psg assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define PSG_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |=> (rhs)) \
        else $error("psg assertion failed");

`endif

[src/psg_pkg.sv]
// ============================================================================
// psg_pkg
// Types, widths and register map of the three-channel sound generator.
// ============================================================================
package psg_pkg;

    localparam int NUM_REGS    = 16;
    localparam int NUM_CH      = 3;
    localparam int TONE_W      = 12;
    localparam int NOISE_W     = 5;
    localparam int LFSR_W      = 17;
    localparam int ENV_PER_W   = 16;
    localparam int LEVEL_W     = 4;

    localparam logic [3:0] REG_TONE_A_LO = 4'd0;
    localparam logic [3:0] REG_NOISE     = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_VOL_A     = 4'd8;
    localparam logic [3:0] REG_ENV_LO    = 4'd11;
    localparam logic [3:0] REG_ENV_HI    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    localparam logic [7:0] MIXER_RESET   = 8'hFF;

    localparam logic [1:0] ENV_STOP = 2'd0;
    localparam logic [1:0] ENV_UP   = 2'd1;
    localparam logic [1:0] ENV_DOWN = 2'd2;

    typedef struct packed {
        logic       action;
        logic [3:0] reg_addr;
        logic [7:0] reg_data;
    } psg_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_a;
        logic [LEVEL_W-1:0] level_b;
        logic [LEVEL_W-1:0] level_c;
    } psg_out_t;

    typedef struct packed {
        logic       tick;
        logic       restart;
        logic [3:0] shape;
    } psg_env_ctl_t;

    function automatic logic [7:0] reg_mask(input logic [3:0] addr);
        logic [7:0] m;
        case (addr)
            4'd1, 4'd3, 4'd5, 4'd13: m = 8'h0F;
            4'd6, 4'd8, 4'd9, 4'd10: m = 8'h1F;
            default:                 m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

[src/psg_tone.sv]
// ============================================================================
// psg_tone
// One square-wave channel: period counter with reload and output toggle.
// ============================================================================
module psg_tone
    import psg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tick,
    input  logic [TONE_W-1:0] reload,
    output logic              bit_next
);

    logic [TONE_W-1:0] count_reg, count_next;
    logic [TONE_W-1:0] period_reg, period_next;
    logic              bit_reg;
    logic [TONE_W:0]   count_inc;
    logic              fire;

    assign count_inc = {1'b0, count_reg} + {{TONE_W{1'b0}}, 1'b1};
    assign fire      = count_inc >= {1'b0, period_reg};

    always_comb begin
        count_next  = count_reg;
        period_next = period_reg;
        bit_next    = bit_reg;
        if (tick) begin
            if (fire) begin
                bit_next    = ~bit_reg;
                count_next  = '0;
                period_next = (reload == '0) ? TONE_W'(1) : reload;
            end else begin
                count_next = count_inc[TONE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            period_reg <= '1;
            bit_reg    <= 1'b0;
        end else begin
            count_reg  <= count_next;
            period_reg <= period_next;
            bit_reg    <= bit_next;
        end
    end

endmodule

[src/psg_noise.sv]
// ============================================================================
// psg_noise
// Noise period counter clocking a 17-bit LFSR (feedback bit0 xor bit2).
// ============================================================================
module psg_noise
    import psg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tick,
    input  logic [NOISE_W-1:0] reload,
    output logic               noise_next
);

    logic [NOISE_W-1:0] count_reg, count_next;
    logic [NOISE_W-1:0] period_reg, period_next;
    logic [LFSR_W-1:0]  shift_reg, shift_next;
    logic [NOISE_W:0]   count_inc;
    logic               fire;

    assign count_inc  = {1'b0, count_reg} + {{NOISE_W{1'b0}}, 1'b1};
    assign fire       = count_inc >= {1'b0, period_reg};
    assign noise_next = shift_next[0];

    always_comb begin
        count_next  = count_reg;
        period_next = period_reg;
        shift_next  = shift_reg;
        if (tick) begin
            if (fire) begin
                shift_next  = {shift_reg[0] ^ shift_reg[2], shift_reg[LFSR_W-1:1]};
                count_next  = '0;
                period_next = (reload == '0) ? NOISE_W'(1) : reload;
            end else begin
                count_next = count_inc[NOISE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            period_reg <= '1;
            shift_reg  <= '1;
        end else begin
            count_reg  <= count_next;
            period_reg <= period_next;
            shift_reg  <= shift_next;
        end
    end

endmodule

[src/psg_env.sv]
// ============================================================================
// psg_env
// Envelope generator: period counter, level ramp and shape control.
// ============================================================================
module psg_env
    import psg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  psg_env_ctl_t         ctl,
    input  logic [ENV_PER_W-1:0] reload,
    output logic [LEVEL_W-1:0]   level_next
);

    logic [ENV_PER_W-1:0] count_reg, count_next;
    logic [ENV_PER_W-1:0] period_reg, period_next;
    logic [LEVEL_W-1:0]   level_reg;
    logic [1:0]           dir_reg, dir_next;
    logic                 hold_reg, hold_next;
    logic                 alt_reg, alt_next;
    logic [ENV_PER_W:0]   count_inc;
    logic                 fire;
    logic [ENV_PER_W-1:0] period_load;
    logic [3:0]           shape;
    logic                 ramp_end;
    logic [LEVEL_W-1:0]   wrap;

    assign count_inc   = {1'b0, count_reg} + {{ENV_PER_W{1'b0}}, 1'b1};
    assign fire        = count_inc >= {1'b0, period_reg};
    assign period_load = (reload == '0) ? ENV_PER_W'(1) : reload;

    always_comb begin
        count_next  = count_reg;
        period_next = period_reg;
        level_next  = level_reg;
        dir_next    = dir_reg;
        hold_next   = hold_reg;
        alt_next    = alt_reg;
        shape       = ctl.shape;
        ramp_end    = 1'b0;
        wrap        = '0;
        if (!ctl.shape[3]) begin
            shape = ctl.shape[2] ? 4'hF : 4'h9;
        end
        if (ctl.restart) begin
            level_next  = shape[2] ? '0 : '1;
            dir_next    = shape[2] ? ENV_UP : ENV_DOWN;
            hold_next   = shape[0];
            alt_next    = shape[1];
            period_next = period_load;
            count_next  = '0;
        end else if (ctl.tick) begin
            if (fire) begin
                count_next  = '0;
                period_next = period_load;
                if (dir_reg == ENV_UP) begin
                    if (level_reg == '1) begin
                        ramp_end = 1'b1;
                        wrap     = '0;
                    end else begin
                        level_next = level_reg + LEVEL_W'(1);
                    end
                end else if (dir_reg == ENV_DOWN) begin
                    if (level_reg == '0) begin
                        ramp_end = 1'b1;
                        wrap     = '1;
                    end else begin
                        level_next = level_reg - LEVEL_W'(1);
                    end
                end
                if (ramp_end) begin
                    if (hold_reg) begin
                        dir_next   = ENV_STOP;
                        level_next = alt_reg ? wrap : ~wrap;
                    end else if (alt_reg) begin
                        level_next = ~wrap;
                        dir_next   = (dir_reg == ENV_UP) ? ENV_DOWN : ENV_UP;
                    end else begin
                        level_next = wrap;
                    end
                end
            end else begin
                count_next = count_inc[ENV_PER_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            period_reg <= '1;
            level_reg  <= '0;
            dir_reg    <= ENV_STOP;
            hold_reg   <= 1'b0;
            alt_reg    <= 1'b0;
        end else begin
            count_reg  <= count_next;
            period_reg <= period_next;
            level_reg  <= level_next;
            dir_reg    <= dir_next;
            hold_reg   <= hold_next;
            alt_reg    <= alt_next;
        end
    end

endmodule

[src/psg_tone_noise_envelope_core.sv]
// ============================================================================
// psg_tone_noise_envelope_core
// Three-channel tone, noise and envelope sound generator, register level.
// ============================================================================
// Input channel (s_valid/s_ready/s_payload): each transfer is either a write
// to one of the 16 chip registers (action = 0) or one prescaled clock tick
// (action = 1). Output channel (m_valid/m_ready/m_payload): exactly one
// transfer per input transfer, carrying the gated 4-bit level of channels
// A, B and C after that item has been applied.
// Path: an accepted item is held in the input register, then the state
// update and the mixer run in one combinational pass into the result
// register, once that register is free or is being emptied.
// Throughput: one item per cycle while m_ready is high.
// Stall: while m_ready is low the result register holds and the input
// register can still take one more transfer; s_ready drops only when both
// are full.
// Reset (aresetn low, synchronous): mixer register all ones, other registers
// zero, tone periods 4095, noise period 31, LFSR all ones, envelope period
// 65535 and stopped, both stages empty.
// ============================================================================
module psg_tone_noise_envelope_core
    import psg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  psg_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output psg_out_t m_payload
);

    logic         in_valid_reg, in_valid_next;
    psg_in_t      in_item_reg;
    logic         out_valid_reg, out_valid_next;
    psg_out_t     out_item_reg;
    logic [7:0]   regs_reg  [NUM_REGS];
    logic [7:0]   regs_next [NUM_REGS];
    logic         advance;
    logic         is_tick;
    logic         is_write;
    logic [NUM_CH-1:0]  tone_bit;
    logic               noise_bit;
    logic [LEVEL_W-1:0] env_level;
    logic [LEVEL_W-1:0] level [NUM_CH];
    psg_env_ctl_t       env_ctl;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || !out_valid_reg || m_ready;
    assign is_tick  = advance && in_item_reg.action;
    assign is_write = advance && !in_item_reg.action;

    assign in_valid_next  = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_comb begin
        for (int r = 0; r < NUM_REGS; r++) begin
            regs_next[r] = regs_reg[r];
            if (is_write && in_item_reg.reg_addr == 4'(r)) begin
                regs_next[r] = in_item_reg.reg_data & reg_mask(4'(r));
            end
        end
    end

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_tone
        psg_tone u_tone (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .tick     (is_tick),
            .reload   ({regs_reg[2*ch+1][3:0], regs_reg[2*ch]}),
            .bit_next (tone_bit[ch])
        );
    end

    psg_noise u_noise (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (is_tick),
        .reload     (regs_reg[REG_NOISE][NOISE_W-1:0]),
        .noise_next (noise_bit)
    );

    assign env_ctl.tick    = is_tick;
    assign env_ctl.restart = is_write && (in_item_reg.reg_addr == REG_ENV_SHAPE);
    assign env_ctl.shape   = in_item_reg.reg_data[3:0];

    psg_env u_env (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (env_ctl),
        .reload     ({regs_reg[REG_ENV_HI], regs_reg[REG_ENV_LO]}),
        .level_next (env_level)
    );

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if ((!regs_next[REG_MIXER][ch] && !tone_bit[ch]) ||
                (!regs_next[REG_MIXER][3+ch] && !noise_bit)) begin
                level[ch] = '0;
            end else if (regs_next[REG_VOL_A + 4'(ch)][4]) begin
                level[ch] = env_level;
            end else begin
                level[ch] = regs_next[REG_VOL_A + 4'(ch)][LEVEL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < NUM_REGS; r++) begin
                regs_reg[r] <= (4'(r) == REG_MIXER) ? MIXER_RESET : 8'h00;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            for (int r = 0; r < NUM_REGS; r++) begin
                regs_reg[r] <= regs_next[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_payload;
        end
        if (advance) begin
            out_item_reg.level_a <= level[0];
            out_item_reg.level_b <= level[1];
            out_item_reg.level_c <= level[2];
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_item_reg;

endmodule

[src/psg_checker.sv]
// ============================================================================
// psg_checker
// Port-level checks of the sound generator handshake and pipeline timing.
// ============================================================================
`include "psg_tone_noise_envelope_core_assert.svh"

module psg_checker
    import psg_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input psg_in_t  s_payload,
    input logic     m_valid,
    input logic     m_ready,
    input psg_out_t m_payload
);

    // stalled input transfer holds
    `PSG_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_payload))

    // stalled result transfer holds
    `PSG_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_payload))

    // with the result register empty the input side never blocks
    `PSG_ASSERT_IMPLY(a_ready_when_empty, !m_valid, s_ready)

    // an accepted item reaches the result register once the output is free
    `PSG_ASSERT_NEXT(a_latency, (s_valid && s_ready) ##1 (m_ready || !m_valid), m_valid)

endmodule

bind psg_tone_noise_envelope_core psg_checker u_psg_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

[tb/tb.sv]
// ============================================================================
// tb
// Self-checking bench for the three-channel tone, noise and envelope core.
// Register writes and prescaled ticks go in over the s_ channel, with random
// gaps. A predictor tracks registers, counters, LFSR and envelope, and each
// m_ transfer is compared field by field with the oldest predicted level set.
// The receiver stalls at random and once holds off long enough to back up the
// input side.
// ============================================================================
module tb;
    import psg_pkg::*;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [3:0] REG_TONE_A_HI = 4'd1;
    localparam logic [3:0] REG_TONE_B_LO = 4'd2;
    localparam logic [3:0] REG_TONE_B_HI = 4'd3;
    localparam logic [3:0] REG_TONE_C_LO = 4'd4;
    localparam logic [3:0] REG_TONE_C_HI = 4'd5;
    localparam logic [3:0] REG_VOL_B     = 4'd9;
    localparam logic [3:0] REG_VOL_C     = 4'd10;
    localparam logic [3:0] REG_PORT_A    = 4'd14;
    localparam logic [3:0] REG_PORT_B    = 4'd15;

    // envelope shape bits
    localparam int SHAPE_HOLD = 0;
    localparam int SHAPE_ALT  = 1;
    localparam int SHAPE_ATT  = 2;
    localparam int SHAPE_CONT = 3;

    localparam int VOL_ENV_BIT = 4;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    psg_in_t  s_payload;
    logic     m_valid;
    logic     m_ready;
    psg_out_t m_payload;

    always #6 aclk = ~aclk;

    psg_tone_noise_envelope_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // ------------------------------------------------------------------------
    // Predictor state
    // ------------------------------------------------------------------------
    logic [7:0]  reg_shadow [NUM_REGS];
    logic [11:0] tone_per [NUM_CH];
    logic [11:0] tone_cnt [NUM_CH];
    logic [2:0]  tone_sq;
    logic [4:0]  noise_per;
    logic [4:0]  noise_cnt;
    logic [16:0] lfsr;
    logic [15:0] env_per;
    logic [15:0] env_cnt;
    logic [3:0]  env_lvl;
    logic [1:0]  env_dir;
    logic [1:0]  env_flags;

    psg_out_t level_q [$];
    int       mismatches;
    bit       src_idle;
    bit       sink_idle;
    int       sink_hold;
    int       sink_stall;

    function automatic logic [7:0] write_mask(input logic [3:0] addr);
        case (addr)
            REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI, REG_ENV_SHAPE: return 8'h0F;
            REG_NOISE, REG_VOL_A, REG_VOL_B, REG_VOL_C:                 return 8'h1F;
            default:                                                    return 8'hFF;
        endcase
    endfunction

    function automatic logic [11:0] tone_reload(input int ch);
        logic [11:0] p;
        p = {reg_shadow[4'(REG_TONE_A_LO + 2 * ch + 1)][3:0],
             reg_shadow[4'(REG_TONE_A_LO + 2 * ch)]};
        return (p == 12'd0) ? 12'd1 : p;
    endfunction

    function automatic logic [15:0] env_reload();
        logic [15:0] p;
        p = {reg_shadow[REG_ENV_HI], reg_shadow[REG_ENV_LO]};
        return (p == 16'd0) ? 16'd1 : p;
    endfunction

    function automatic void reset_model();
        for (int r = 0; r < NUM_REGS; r++) reg_shadow[4'(r)] = 8'h00;
        reg_shadow[REG_MIXER] = MIXER_RESET;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            tone_per[ch] = 12'hFFF;
            tone_cnt[ch] = 12'd0;
        end
        tone_sq   = 3'b000;
        noise_per = 5'h1F;
        noise_cnt = 5'd0;
        lfsr      = '1;
        env_per   = 16'hFFFF;
        env_cnt   = 16'd0;
        env_lvl   = 4'd0;
        env_dir   = ENV_STOP;
        env_flags = 2'b00;
    endfunction

    function automatic void restart_envelope(input logic [3:0] c);
        if (!c[SHAPE_CONT]) c = c[SHAPE_ATT] ? 4'hF : 4'h9;
        env_lvl   = c[SHAPE_ATT] ? 4'd0 : 4'd15;
        env_dir   = c[SHAPE_ATT] ? ENV_UP : ENV_DOWN;
        env_flags = c[1:0];
        env_per   = env_reload();
        env_cnt   = 16'd0;
    endfunction

    function automatic void step_envelope();
        int nxt;
        logic [3:0] w;
        if (env_dir == ENV_UP) nxt = int'(env_lvl) + 1;
        else if (env_dir == ENV_DOWN) nxt = int'(env_lvl) - 1;
        else return;
        if (nxt >= 0 && nxt <= 15) begin
            env_lvl = 4'(nxt);
            return;
        end
        w = (nxt > 15) ? 4'h0 : 4'hF;
        if (env_flags[SHAPE_HOLD]) begin
            env_dir = ENV_STOP;
            if (!env_flags[SHAPE_ALT]) w = ~w;
        end else if (env_flags[SHAPE_ALT]) begin
            w = ~w;
            env_dir = (env_dir == ENV_UP) ? ENV_DOWN : ENV_UP;
        end
        env_lvl = w;
    endfunction

    function automatic void advance_tick();
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (int'(tone_cnt[ch]) + 1 >= int'(tone_per[ch])) begin
                tone_sq[ch]  = ~tone_sq[ch];
                tone_cnt[ch] = 12'd0;
                tone_per[ch] = tone_reload(ch);
            end else begin
                tone_cnt[ch] = tone_cnt[ch] + 12'd1;
            end
        end
        if (int'(noise_cnt) + 1 >= int'(noise_per)) begin
            lfsr      = {lfsr[0] ^ lfsr[2], lfsr[16:1]};
            noise_cnt = 5'd0;
            noise_per = reg_shadow[REG_NOISE][4:0];
            if (noise_per == 5'd0) noise_per = 5'd1;
        end else begin
            noise_cnt = noise_cnt + 5'd1;
        end
        if (int'(env_cnt) + 1 >= int'(env_per)) begin
            step_envelope();
            env_cnt = 16'd0;
            env_per = env_reload();
        end else begin
            env_cnt = env_cnt + 16'd1;
        end
    endfunction

    function automatic logic [3:0] gated_level(input int ch);
        logic [7:0] mix;
        logic [7:0] vol;
        mix = reg_shadow[REG_MIXER];
        vol = reg_shadow[4'(REG_VOL_A + ch)];
        if (!mix[3'(ch)] && !tone_sq[2'(ch)]) return 4'd0;
        if (!mix[3'(3 + ch)] && !lfsr[0]) return 4'd0;
        return vol[VOL_ENV_BIT] ? env_lvl : vol[3:0];
    endfunction

    function automatic psg_out_t predict_levels(input psg_in_t it);
        psg_out_t r;
        logic [7:0] d;
        if (it.action == ACT_TICK) begin
            advance_tick();
        end else begin
            d = it.reg_data & write_mask(it.reg_addr);
            reg_shadow[it.reg_addr] = d;
            if (it.reg_addr == REG_ENV_SHAPE) restart_envelope(d[3:0]);
        end
        r.level_a = gated_level(0);
        r.level_b = gated_level(1);
        r.level_c = gated_level(2);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_item(input psg_in_t it);
        if (src_idle && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        level_q.push_back(predict_levels(it));
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [7:0] data);
        psg_in_t it;
        it.action   = ACT_WRITE;
        it.reg_addr = addr;
        it.reg_data = data;
        send_item(it);
    endtask

    task automatic tick_n(input int n);
        psg_in_t it;
        repeat (n) begin
            it.action   = ACT_TICK;
            it.reg_addr = 4'($urandom);
            it.reg_data = 8'($urandom);
            send_item(it);
        end
    endtask

    // Mostly short periods so counters wrap often; tone regs optional.
    task automatic send_random_item(input bit tones_too, input int tick_pct);
        logic [3:0] addr;
        logic [7:0] data;
        if ($urandom_range(0, 99) < tick_pct) begin
            tick_n(1);
            return;
        end
        do addr = 4'($urandom_range(0, 15)); while (!tones_too && addr < REG_NOISE);
        data = 8'($urandom_range(0, 255));
        case (addr)
            REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: begin
                if ($urandom_range(0, 31) != 0) data[3:0] = 4'h0;
            end
            REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO: begin
                if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 15));
            end
            REG_ENV_HI: begin
                if ($urandom_range(0, 31) != 0) data = 8'h00;
            end
            REG_ENV_LO: begin
                if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 3));
            end
            default: ;
        endcase
        write_reg(addr, data);
    endtask

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------
    initial begin
        m_ready    = 1'b0;
        sink_stall = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold--;
            end else if (sink_stall > 0) begin
                m_ready <= 1'b0;
                sink_stall--;
            end else if (sink_idle && $urandom_range(0, 11) == 0) begin
                m_ready <= 1'b0;
                sink_stall = int'($urandom_range(0, 13));
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic check_level(input string field, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        psg_out_t oldest;
        if (aresetn && m_valid && m_ready) begin
            if (level_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none actual %h",
                         $time, m_payload);
                mismatches++;
            end else begin
                oldest = level_q.pop_front();
                check_level("level_a", oldest.level_a, m_payload.level_a);
                check_level("level_b", oldest.level_b, m_payload.level_b);
                check_level("level_c", oldest.level_c, m_payload.level_c);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Every register once with masked bits set, zero periods, repeated shape
    // write, shape without the continue bit.
    task automatic test_directed();
        write_reg(REG_TONE_A_LO, 8'hFF);
        write_reg(REG_TONE_A_HI, 8'hFF);
        write_reg(REG_TONE_B_LO, 8'h00);
        write_reg(REG_TONE_B_HI, 8'h00);
        write_reg(REG_TONE_C_LO, 8'h03);
        write_reg(REG_TONE_C_HI, 8'hF0);
        write_reg(REG_NOISE, 8'hE0);
        write_reg(REG_MIXER, 8'hC0);
        write_reg(REG_VOL_A, 8'hFF);
        write_reg(REG_VOL_B, 8'h0F);
        write_reg(REG_VOL_C, 8'hF5);
        write_reg(REG_ENV_LO, 8'h00);
        write_reg(REG_ENV_HI, 8'h00);
        write_reg(REG_ENV_SHAPE, 8'hFE);
        write_reg(REG_PORT_A, 8'hFF);
        write_reg(REG_PORT_B, 8'h00);
        tick_n(3);
        write_reg(REG_ENV_SHAPE, 8'hFE);
        tick_n(2);
        write_reg(REG_ENV_SHAPE, 8'h00);
        tick_n(2);
    endtask

    // Short tone periods written while the reset period 4095 is still latched;
    // long tick stretch with noise and envelope activity.
    task automatic test_tone_first_reload();
        for (int ch = 0; ch < NUM_CH; ch++) begin
            write_reg(4'(REG_TONE_A_LO + 2 * ch), 8'($urandom_range(0, 12)));
            write_reg(4'(REG_TONE_A_LO + 2 * ch + 1), {4'($urandom_range(0, 15)), 4'h0});
        end
        repeat (600) send_random_item(1'b0, 95);
    endtask

    task automatic test_env_shapes();
        write_reg(REG_MIXER, 8'hFF);
        write_reg(REG_VOL_A, 8'h10);
        write_reg(REG_VOL_B, 8'h1F);
        write_reg(REG_VOL_C, 8'h15);
        for (int s = 0; s < 16; s++) begin
            write_reg(REG_ENV_LO, 8'($urandom_range(0, 1)));
            write_reg(REG_ENV_HI, 8'h00);
            write_reg(REG_ENV_SHAPE, {4'($urandom_range(0, 15)), 4'(s)});
            tick_n(20);
        end
    endtask

    task automatic test_backpressure();
        src_idle  = 1'b0;
        sink_hold = 80;
        repeat (40) send_random_item(1'b1, 80);
        src_idle  = 1'b1;
    endtask

    task automatic test_random();
        for (int i = 0; i < 900; i++) begin
            if (i == 700) begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end
            send_random_item(1'b1, 70);
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_payload  = '0;
        src_idle   = 1'b1;
        sink_idle  = 1'b1;
        sink_hold  = 0;
        mismatches = 0;
        reset_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_tone_first_reload();
        test_env_shapes();
        test_backpressure();
        test_random();
        s_valid <= 1'b0;
        while (level_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS psg_tone_noise_envelope_core");
        end else begin
            $display("FAIL psg_tone_noise_envelope_core");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("FAIL psg_tone_noise_envelope_core");
        $finish;
    end

endmodule

[psg_tone_noise_envelope_core.f]
+incdir+src
src/psg_pkg.sv
src/psg_tone.sv
src/psg_noise.sv
src/psg_env.sv
src/psg_tone_noise_envelope_core.sv
src/psg_checker.sv
tb/tb.sv
